@@ rtl/core/bld_pkg.sv @@
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and constants of the backlight auto dimmer.
// ----------------------------------------------------------------------------
package bld_pkg;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_ACTIVITY = 3'd1,
    ACT_WAKE     = 3'd2,
    ACT_RESTORE  = 3'd3,
    ACT_SET_USER = 3'd4,
    ACT_MODE     = 3'd5,
    ACT_LUX      = 3'd6,
    ACT_NOP      = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_FADING = 2'd1,
    PH_DIMMED = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_DIM_ENABLE   = 3'd0,
    REG_DIM_LEVEL    = 3'd1,
    REG_DIM_INTERVAL = 3'd2,
    REG_START_BRIGHT = 3'd3,
    REG_LUX_MIN      = 3'd4,
    REG_LUX_MAX      = 3'd5,
    REG_AMBIENT_MIN  = 3'd6,
    REG_SMOOTH_ALPHA = 3'd7
  } reg_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] value;
    logic        suspended;
  } item_t;

  localparam logic        RST_DIM_ENABLE   = 1'b1;
  localparam logic [6:0]  RST_DIM_LEVEL    = 7'd2;
  localparam logic [11:0] RST_DIM_INTERVAL = 12'd60;
  localparam logic [6:0]  RST_START_BRIGHT = 7'd100;
  localparam logic [15:0] RST_LUX_MIN      = 16'd10;
  localparam logic [15:0] RST_LUX_MAX      = 16'd8000;
  localparam logic [6:0]  RST_AMBIENT_MIN  = 7'd5;
  localparam logic [6:0]  RST_SMOOTH_ALPHA = 7'd25;

  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [15:0] LUX_SAT   = 16'hFFFF;
  localparam logic [21:0] MS_PER_S  = 22'd1000;

endpackage

@@ rtl/core/bld_if.sv @@
// ----------------------------------------------------------------------------
// bld_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface bld_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] value;
  logic        suspended;
  modport source (output valid, action, value, suspended, input ready);
  modport sink   (input valid, action, value, suspended, output ready);
endinterface

interface bld_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  brightness;
  logic        drive_write;
  logic [1:0]  dim_phase;
  logic        ignore_touch;
  logic [15:0] lux_smoothed;
  logic [6:0]  ambient_target;
  modport source (output valid, brightness, drive_write, dim_phase, ignore_touch,
                  lux_smoothed, ambient_target, input ready);
  modport sink   (input valid, brightness, drive_write, dim_phase, ignore_touch,
                  lux_smoothed, ambient_target, output ready);
endinterface

interface bld_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/bld_front.sv @@
// ----------------------------------------------------------------------------
// bld_front
// Input side: accepts transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bld_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bld_in_if.sink        in_i,
  output logic          item_valid_o,
  output bld_pkg::item_t item_o,
  input  logic          item_pop_i
);

  bld_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ item_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, item_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{action:    bld_pkg::action_e'(in_i.action),
                           value:     in_i.value,
                           suspended: in_i.suspended};
    end
  end

endmodule

@@ rtl/core/bld_div.sv @@
// ----------------------------------------------------------------------------
// bld_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bld_div #(
  parameter int DW = 26,
  parameter int VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [VW:0]   trial;
  logic          fits;

  assign trial  = {rem_q, quo_q[DW-1]};
  assign fits   = (trial >= {1'b0, div_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

endmodule

@@ rtl/core/bld_core.sv @@
// ----------------------------------------------------------------------------
// bld_core
// Back end: register file, dimming state machine, ambient lux path and
// result register.
// ----------------------------------------------------------------------------
module bld_core #(
  parameter int FADE_STEP_PCT    = 1,
  parameter int FADE_PERIOD_MS   = 1000,
  parameter int WAKE_WINDOW_MS   = 500,
  parameter int GAMMA_INDEX_BITS = 8,
  parameter int DIV_W            = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bld_cfg_if.sink          cfg_i,
  input  logic             item_valid_i,
  input  bld_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             div_start_o,
  output logic [DIV_W-1:0] div_dividend_o,
  output logic [16:0]      div_divisor_o,
  input  logic             div_done_i,
  input  logic [DIV_W-1:0] div_quot_i,
  bld_out_if.source        out_o
);

  localparam int GB     = GAMMA_INDEX_BITS;
  localparam int ROM_N  = 1 << GB;
  localparam int M      = ROM_N - 1;
  localparam int IDX_NW = 18 + GB;

  // reciprocals: ceil(2^22 / 3) and ceil(2^30 / 100), exact over the operand ranges
  localparam logic [20:0] RECIP_3   = 21'd1398102;
  localparam logic [23:0] RECIP_100 = 24'd10737419;

  typedef logic [8:0] rom_t [ROM_N];

  function automatic rom_t gamma_rom();
    rom_t r;
    longint unsigned x;
    longint unsigned c;
    longint unsigned dd;
    int cnt;
    dd = longint'(M) * longint'(M) * longint'(M);
    for (int i = 0; i < ROM_N; i++) begin
      x   = (longint'(i) * longint'(i) * longint'(i)) << 30;
      cnt = 0;
      for (int y = 1; y <= 256; y++) begin
        c = longint'(2 * y - 1);
        c = c * c * c * c * c;
        if (((c + 64'd32767) >> 15) * dd <= x) cnt++;
      end
      r[i] = 9'(cnt);
    end
    return r;
  endfunction

  localparam rom_t GAMMA_ROM = gamma_rom();

  typedef enum logic [2:0] {
    S_IDLE, S_AVG, S_SCALE, S_IDX, S_DIV_IDX, S_ROM, S_TGT, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic        en_q, en_d;
  logic [6:0]  dim_level_q, dim_level_d;
  logic [11:0] interval_q, interval_d;
  logic [15:0] lmin_q, lmin_d;
  logic [15:0] lmax_q, lmax_d;
  logic [6:0]  amin_q, amin_d;
  logic [6:0]  alpha_q, alpha_d;

  bld_pkg::phase_e phase_q, phase_d;
  logic        captured_q, captured_d;
  logic [6:0]  baseline_q, baseline_d;
  logic [6:0]  level_q, level_d;
  logic [6:0]  goal_q, goal_d;
  logic [6:0]  saved_q, saved_d;
  logic [21:0] idle_q, idle_d;
  logic [9:0]  fade_q, fade_d;
  logic [8:0]  wake_q, wake_d;
  logic [15:0] avg_q, avg_d;
  logic [6:0]  amb_q, amb_d;
  logic        drive_q, drive_d;
  logic [15:0] lux_q, lux_d;
  logic [22:0] num_q, num_d;
  logic [GB-1:0] idx_q, idx_d;
  logic [8:0]  rom_q;

  logic        ov_q, ov_d;
  logic [6:0]  o_bright_q, o_bright_d;
  logic        o_drive_q, o_drive_d;
  logic [1:0]  o_phase_q, o_phase_d;
  logic        o_ign_q, o_ign_d;
  logic [15:0] o_lux_q, o_lux_d;
  logic [6:0]  o_amb_q, o_amb_d;

  logic [20:0]       lux_num;
  logic [41:0]       lux_prod;
  logic [15:0]       lux_sat;
  logic [15:0]       lux_base;
  logic [6:0]        alpha_c;
  logic [22:0]       avg_num;
  logic [46:0]       avg_prod;
  logic [15:0]       v_clamp;
  logic [15:0]       span;
  logic [IDX_NW-1:0] idx_num;
  logic signed [17:0] tot;
  logic signed [17:0] diff;
  logic [7:0]        t_raw;
  logic [6:0]        t_cap;
  logic [6:0]        cap;
  logic [6:0]        want;
  logic [6:0]        pct;

  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = ov_q;
  assign out_o.brightness     = o_bright_q;
  assign out_o.drive_write    = o_drive_q;
  assign out_o.dim_phase      = o_phase_q;
  assign out_o.ignore_touch   = o_ign_q;
  assign out_o.lux_smoothed   = o_lux_q;
  assign out_o.ambient_target = o_amb_q;

  always_ff @(posedge clk_i) begin
    rom_q <= GAMMA_ROM[idx_q];
  end

  // lux datapath
  always_comb begin
    lux_num  = 21'(item_i.value) * 21'd25 + 21'd1;
    lux_prod = 42'(lux_num) * 42'(RECIP_3);
    lux_sat  = (|lux_prod[41:38]) ? bld_pkg::LUX_SAT : lux_prod[37:22];
    lux_base = (avg_q == 16'd0) ? lux_q : avg_q;
    alpha_c  = (alpha_q > bld_pkg::PCT_MAX) ? bld_pkg::PCT_MAX : alpha_q;
    avg_num  = 23'(lux_base) * 23'(bld_pkg::PCT_MAX - alpha_c) + 23'(lux_q) * 23'(alpha_c);
    avg_prod = 47'(num_q) * 47'(RECIP_100);
    v_clamp  = (avg_q < lmin_q) ? lmin_q : avg_q;
    if (v_clamp > lmax_q) v_clamp = lmax_q;
    span     = lmax_q - lmin_q;
    idx_num  = IDX_NW'(v_clamp - lmin_q) * IDX_NW'(M) * IDX_NW'(2) + IDX_NW'(span);
    diff     = 18'sd100 - signed'(18'(amin_q));
    tot      = (signed'(18'(amin_q)) <<< 8) + signed'(18'(rom_q)) * diff;
    t_raw    = (tot < 0) ? 8'd0 : 8'((tot + 18'sd128) >>> 8);
    t_cap    = (t_raw > 8'(bld_pkg::PCT_MAX)) ? bld_pkg::PCT_MAX : t_raw[6:0];
    cap      = (baseline_q != 7'd0) ? baseline_q : saved_q;
    if (t_cap > cap) t_cap = cap;
    want     = (baseline_q < t_cap) ? baseline_q : t_cap;
    pct      = (item_i.value > 16'(bld_pkg::PCT_MAX)) ? bld_pkg::PCT_MAX : item_i.value[6:0];
  end

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    dim_level_d = dim_level_q;
    interval_d  = interval_q;
    lmin_d      = lmin_q;
    lmax_d      = lmax_q;
    amin_d      = amin_q;
    alpha_d     = alpha_q;
    phase_d     = phase_q;
    captured_d  = captured_q;
    baseline_d  = baseline_q;
    level_d     = level_q;
    goal_d      = goal_q;
    saved_d     = saved_q;
    idle_d      = idle_q;
    fade_d      = fade_q;
    wake_d      = wake_q;
    avg_d       = avg_q;
    amb_d       = amb_q;
    drive_d     = drive_q;
    lux_d       = lux_q;
    num_d       = num_q;
    idx_d       = idx_q;
    ov_d        = ov_q && !out_o.ready;
    o_bright_d  = o_bright_q;
    o_drive_d   = o_drive_q;
    o_phase_d   = o_phase_q;
    o_ign_d     = o_ign_q;
    o_lux_d     = o_lux_q;
    o_amb_d     = o_amb_q;
    item_pop_o     = 1'b0;
    div_start_o    = 1'b0;
    div_dividend_o = DIV_W'(idx_num);
    div_divisor_o  = {span, 1'b0};

    if (cfg_i.valid) begin
      unique case (bld_pkg::reg_e'(cfg_i.index))
        bld_pkg::REG_DIM_ENABLE:   en_d        = cfg_i.data[0];
        bld_pkg::REG_DIM_LEVEL:    dim_level_d = cfg_i.data[6:0];
        bld_pkg::REG_DIM_INTERVAL: interval_d  = cfg_i.data[11:0];
        bld_pkg::REG_START_BRIGHT: begin
          saved_d = (cfg_i.data[6:0] > bld_pkg::PCT_MAX) ? bld_pkg::PCT_MAX : cfg_i.data[6:0];
        end
        bld_pkg::REG_LUX_MIN:      lmin_d      = cfg_i.data;
        bld_pkg::REG_LUX_MAX:      lmax_d      = cfg_i.data;
        bld_pkg::REG_AMBIENT_MIN:  amin_d      = cfg_i.data[6:0];
        bld_pkg::REG_SMOOTH_ALPHA: alpha_d     = cfg_i.data[6:0];
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          drive_d    = 1'b0;
          state_d    = S_OUT;
          unique case (item_i.action)
            bld_pkg::ACT_TICK: begin
              idle_d = (&idle_q) ? idle_q : idle_q + 22'd1;
              fade_d = (&fade_q) ? fade_q : fade_q + 10'd1;
              wake_d = (&wake_q) ? wake_q : wake_q + 9'd1;
              if (en_q) begin
                if (!captured_q) begin
                  baseline_d = saved_q;
                  level_d    = saved_q;
                  captured_d = 1'b1;
                  idle_d     = '0;
                end
                if (!item_i.suspended) begin
                  if (phase_q == bld_pkg::PH_WAIT) begin
                    if (idle_d > 22'(interval_q) * bld_pkg::MS_PER_S) begin
                      goal_d  = dim_level_q;
                      phase_d = bld_pkg::PH_FADING;
                      fade_d  = '0;
                    end
                  end else if (phase_q == bld_pkg::PH_FADING) begin
                    if (fade_d >= 10'(FADE_PERIOD_MS)) begin
                      fade_d = '0;
                      if (level_d > goal_q) begin
                        if ({1'b0, level_d} <= {1'b0, goal_q} + 8'(FADE_STEP_PCT)) begin
                          level_d = goal_q;
                        end else begin
                          level_d = level_d - 7'(FADE_STEP_PCT);
                        end
                        drive_d = 1'b1;
                      end else begin
                        phase_d = bld_pkg::PH_DIMMED;
                      end
                    end
                  end
                end
              end
            end
            bld_pkg::ACT_ACTIVITY: idle_d = '0;
            bld_pkg::ACT_WAKE, bld_pkg::ACT_RESTORE, bld_pkg::ACT_MODE: begin
              if (en_q || item_i.action == bld_pkg::ACT_RESTORE) begin
                if (!captured_q) begin
                  baseline_d = saved_q;
                  captured_d = 1'b1;
                end
                if (item_i.action == bld_pkg::ACT_MODE &&
                    (item_i.suspended || phase_q == bld_pkg::PH_WAIT)) begin
                  if (!captured_q) level_d = saved_q;
                  if (!item_i.suspended) idle_d = '0;
                end else begin
                  level_d = baseline_d;
                  goal_d  = baseline_d;
                  idle_d  = '0;
                  fade_d  = '0;
                  phase_d = bld_pkg::PH_WAIT;
                  drive_d = 1'b1;
                  if (item_i.action != bld_pkg::ACT_RESTORE) wake_d = '0;
                end
              end
            end
            bld_pkg::ACT_SET_USER: begin
              baseline_d = pct;
              level_d    = pct;
              goal_d     = pct;
              saved_d    = pct;
              captured_d = 1'b1;
              idle_d     = '0;
              fade_d     = '0;
              wake_d     = '0;
              phase_d    = bld_pkg::PH_WAIT;
              drive_d    = 1'b1;
            end
            bld_pkg::ACT_LUX: begin
              if (en_q) begin
                if (!captured_q) begin
                  baseline_d = saved_q;
                  level_d    = saved_q;
                  captured_d = 1'b1;
                end
                if (!item_i.suspended) begin
                  lux_d   = lux_sat;
                  state_d = S_AVG;
                end
              end
            end
            bld_pkg::ACT_NOP: ;
          endcase
        end
      end
      S_AVG: begin
        num_d   = avg_num;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        avg_d   = avg_prod[45:30];
        state_d = S_IDX;
      end
      S_IDX: begin
        if (lmax_q > lmin_q) begin
          div_start_o = 1'b1;
          state_d     = S_DIV_IDX;
        end else begin
          idx_d   = '0;
          state_d = S_ROM;
        end
      end
      S_DIV_IDX: begin
        if (div_done_i) begin
          idx_d   = (div_quot_i > DIV_W'(M)) ? GB'(M) : div_quot_i[GB-1:0];
          state_d = S_ROM;
        end
      end
      S_ROM: state_d = S_TGT;
      S_TGT: begin
        amb_d = t_cap;
        if (phase_q == bld_pkg::PH_WAIT && level_q != want) begin
          if (level_q < want) begin
            level_d = ({1'b0, level_q} + 8'd2 > {1'b0, want}) ? want : level_q + 7'd2;
          end else begin
            level_d = ({1'b0, level_q} < {1'b0, want} + 8'd2) ? want : level_q - 7'd2;
          end
          drive_d = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          o_bright_d = level_q;
          o_drive_d  = drive_q;
          o_phase_d  = phase_q;
          o_ign_d    = (wake_q < 9'(WAKE_WINDOW_MS));
          o_lux_d    = avg_q;
          o_amb_d    = amb_q;
          state_d    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      en_q        <= bld_pkg::RST_DIM_ENABLE;
      dim_level_q <= bld_pkg::RST_DIM_LEVEL;
      interval_q  <= bld_pkg::RST_DIM_INTERVAL;
      lmin_q      <= bld_pkg::RST_LUX_MIN;
      lmax_q      <= bld_pkg::RST_LUX_MAX;
      amin_q      <= bld_pkg::RST_AMBIENT_MIN;
      alpha_q     <= bld_pkg::RST_SMOOTH_ALPHA;
      phase_q     <= bld_pkg::PH_WAIT;
      captured_q  <= 1'b0;
      baseline_q  <= '0;
      level_q     <= '0;
      goal_q      <= '0;
      saved_q     <= bld_pkg::RST_START_BRIGHT;
      idle_q      <= '0;
      fade_q      <= '0;
      wake_q      <= '0;
      avg_q       <= '0;
      amb_q       <= '0;
      drive_q     <= 1'b0;
      lux_q       <= '0;
      num_q       <= '0;
      idx_q       <= '0;
      ov_q        <= 1'b0;
      o_bright_q  <= '0;
      o_drive_q   <= 1'b0;
      o_phase_q   <= '0;
      o_ign_q     <= 1'b0;
      o_lux_q     <= '0;
      o_amb_q     <= '0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      dim_level_q <= dim_level_d;
      interval_q  <= interval_d;
      lmin_q      <= lmin_d;
      lmax_q      <= lmax_d;
      amin_q      <= amin_d;
      alpha_q     <= alpha_d;
      phase_q     <= phase_d;
      captured_q  <= captured_d;
      baseline_q  <= baseline_d;
      level_q     <= level_d;
      goal_q      <= goal_d;
      saved_q     <= saved_d;
      idle_q      <= idle_d;
      fade_q      <= fade_d;
      wake_q      <= wake_d;
      avg_q       <= avg_d;
      amb_q       <= amb_d;
      drive_q     <= drive_d;
      lux_q       <= lux_d;
      num_q       <= num_d;
      idx_q       <= idx_d;
      ov_q        <= ov_d;
      o_bright_q  <= o_bright_d;
      o_drive_q   <= o_drive_d;
      o_phase_q   <= o_phase_d;
      o_ign_q     <= o_ign_d;
      o_lux_q     <= o_lux_d;
      o_amb_q     <= o_amb_d;
    end
  end

endmodule

@@ rtl/core/backlight_auto_dimmer.sv @@
// ----------------------------------------------------------------------------
// backlight_auto_dimmer
// Idle dimmer with ambient light tracking for a display backlight.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. Transactions
// enter a two-entry queue; the back end takes them one at a time. Ticks,
// activity, wake, restore, user set and mode change go from the idle state
// to the result state. A lux sample scales and smooths the reading by
// reciprocal multiplication, divides by the lux span on a radix-2 divider
// (DIV_W = 18 + GAMMA_INDEX_BITS bits) and reads the gamma ROM, skipping the
// divider when the lux ceiling is not above the floor. A stalled result
// receiver holds the back end. The user is to write registers through the
// config channel only while the block is idle; it is not enforced.
module backlight_auto_dimmer #(
  parameter int FADE_STEP_PCT    = 1,
  parameter int FADE_PERIOD_MS   = 1000,
  parameter int WAKE_WINDOW_MS   = 500,
  parameter int GAMMA_INDEX_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bld_in_if.sink    in_i,
  bld_cfg_if.sink   cfg_i,
  bld_out_if.source out_o
);

  localparam int DIV_W = 18 + GAMMA_INDEX_BITS;

  logic             item_valid;
  bld_pkg::item_t   item;
  logic             item_pop;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [16:0]      div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  bld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  bld_div #(.DW(DIV_W), .VW(17)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  bld_core #(
    .FADE_STEP_PCT    (FADE_STEP_PCT),
    .FADE_PERIOD_MS   (FADE_PERIOD_MS),
    .WAKE_WINDOW_MS   (WAKE_WINDOW_MS),
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS),
    .DIV_W            (DIV_W)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .out_o          (out_o)
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid) else $error("queue popped while empty");

  a_full_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> item_valid) else $error("input stalled with empty queue");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_start) else $error("divider restarted back to back");
`endif

endmodule

@@ tb/bld_checker.sv @@
// ----------------------------------------------------------------------------
// bld_checker
// Watches the input, register and result channels of the backlight auto
// dimmer, predicts one result per accepted input transaction from its own
// copy of the dimmer state and compares every result field by field.
// ----------------------------------------------------------------------------
module bld_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bld_in_if    in_mon,
  bld_cfg_if   cfg_mon,
  bld_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEP_PCT  = 1;
  localparam int unsigned PERIOD_MS = 1000;
  localparam int unsigned WINDOW_MS = 500;
  localparam int unsigned IDX_BITS  = 8;
  localparam int unsigned IDLE_SAT  = 4194303;
  localparam int unsigned FADE_SAT  = 1023;
  localparam int unsigned WAKE_SAT  = 511;

  typedef struct packed {
    logic [6:0]       brightness;
    logic             drive_write;
    bld_pkg::phase_e  dim_phase;
    logic             ignore_touch;
    logic [15:0]      lux_smoothed;
    logic [6:0]       ambient_target;
  } result_t;

  // register copies
  logic        r_enable;
  int unsigned r_dim_level, r_interval, r_start, r_lux_min, r_lux_max, r_amb_min, r_alpha;

  // dimmer state
  bld_pkg::phase_e ph;
  logic        captured;
  int unsigned baseline, lamp, goal, saved, idle_ms, fade_ms, wake_ms, lux_avg, amb_goal;

  result_t     expected_q[$];
  int          n_err;

  assign errors_o  = n_err;
  assign pending_o = expected_q.size();

  function automatic int unsigned pct_clip(int unsigned v);
    return (v > 100) ? 100 : v;
  endfunction

  function automatic void take_baseline();
    if (!captured) begin
      baseline = saved;
      lamp     = saved;
      captured = 1'b1;
    end
  endfunction

  function automatic void back_to_baseline();
    take_baseline();
    lamp    = baseline;
    goal    = baseline;
    idle_ms = 0;
    fade_ms = 0;
    ph      = bld_pkg::PH_WAIT;
  endfunction

  function automatic int unsigned gamma_q8(longint unsigned idx, longint unsigned m);
    longint unsigned thr, x;
    int unsigned lo, hi, mid;
    thr = ((idx * idx * idx) << 30) / (m * m * m);
    thr = thr << 15;
    lo = 0;
    hi = 256;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      x = 2 * longint'(mid) - 1;
      if (x * x * x * x * x <= thr) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic track_ambient(int unsigned raw);
    int unsigned lux, a, v, idx, t, cap, want;
    longint unsigned m, span, d;
    int tot;
    lux = (raw * 25 + 1) / 3;
    a   = (r_alpha > 100) ? 100 : r_alpha;
    m   = (64'd1 << IDX_BITS) - 1;
    idx = 0;
    if (lux > 65535) lux = 65535;
    if (lux_avg == 0) lux_avg = lux;
    lux_avg = (lux_avg * (100 - a) + lux * a) / 100;
    v = lux_avg;
    if (v < r_lux_min) v = r_lux_min;
    if (v > r_lux_max) v = r_lux_max;
    if (r_lux_max > r_lux_min) begin
      span = r_lux_max - r_lux_min;
      d    = (v >= r_lux_min) ? v - r_lux_min : 0;
      idx  = int'((d * m * 2 + span) / (2 * span));
      if (idx > m) idx = int'(m);
    end
    tot = int'(r_amb_min) * 256 + int'(gamma_q8(idx, m)) * (100 - int'(r_amb_min));
    if (tot < 0) tot = 0;
    t   = pct_clip((int'(tot) + 128) >> 8);
    cap = (baseline != 0) ? baseline : saved;
    if (t > cap) t = cap;
    amb_goal = t;
    if (ph == bld_pkg::PH_WAIT) begin
      want = (baseline < amb_goal) ? baseline : amb_goal;
      if (lamp != want) begin
        if (lamp < want) lamp = (lamp + 2 > want) ? want : lamp + 2;
        else lamp = (lamp < want + 2) ? want : lamp - 2;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic advance_ms(logic susp);
    idle_ms = (idle_ms < IDLE_SAT) ? idle_ms + 1 : IDLE_SAT;
    fade_ms = (fade_ms < FADE_SAT) ? fade_ms + 1 : FADE_SAT;
    wake_ms = (wake_ms < WAKE_SAT) ? wake_ms + 1 : WAKE_SAT;
    if (!r_enable) return 1'b0;
    if (!captured) begin
      take_baseline();
      idle_ms = 0;
    end
    if (susp) return 1'b0;
    if (ph == bld_pkg::PH_WAIT) begin
      if (idle_ms > r_interval * 1000) begin
        goal    = r_dim_level;
        ph      = bld_pkg::PH_FADING;
        fade_ms = 0;
      end
    end else if (ph == bld_pkg::PH_FADING) begin
      if (fade_ms < PERIOD_MS) return 1'b0;
      fade_ms = 0;
      if (lamp > goal) begin
        if (lamp <= goal + STEP_PCT) lamp = goal;
        else lamp = lamp - STEP_PCT;
        return 1'b1;
      end
      ph = bld_pkg::PH_DIMMED;
    end
    return 1'b0;
  endfunction

  function automatic result_t dimmer_step(bld_pkg::item_t it);
    result_t     r;
    logic        drive;
    int unsigned p;
    drive = 1'b0;
    case (it.action)
      bld_pkg::ACT_TICK: begin
        drive = advance_ms(it.suspended);
      end
      bld_pkg::ACT_ACTIVITY: begin
        idle_ms = 0;
      end
      bld_pkg::ACT_WAKE: begin
        if (r_enable) begin
          back_to_baseline();
          wake_ms = 0;
          drive   = 1'b1;
        end
      end
      bld_pkg::ACT_RESTORE: begin
        back_to_baseline();
        drive = 1'b1;
      end
      bld_pkg::ACT_SET_USER: begin
        p        = pct_clip(it.value);
        baseline = p;
        lamp     = p;
        goal     = p;
        saved    = p;
        captured = 1'b1;
        idle_ms  = 0;
        fade_ms  = 0;
        wake_ms  = 0;
        ph       = bld_pkg::PH_WAIT;
        drive    = 1'b1;
      end
      bld_pkg::ACT_MODE: begin
        if (r_enable) begin
          take_baseline();
          if (!it.suspended) begin
            if (ph == bld_pkg::PH_FADING || ph == bld_pkg::PH_DIMMED) begin
              back_to_baseline();
              wake_ms = 0;
              drive   = 1'b1;
            end else begin
              idle_ms = 0;
            end
          end
        end
      end
      bld_pkg::ACT_LUX: begin
        if (r_enable) begin
          take_baseline();
          if (!it.suspended) drive = track_ambient(it.value);
        end
      end
      default: ;
    endcase
    r.brightness     = lamp[6:0];
    r.drive_write    = drive;
    r.dim_phase      = ph;
    r.ignore_touch   = (wake_ms < WINDOW_MS);
    r.lux_smoothed   = lux_avg[15:0];
    r.ambient_target = amb_goal[6:0];
    return r;
  endfunction

  task automatic check_result(result_t exp_r, result_t got);
    if (exp_r.brightness !== got.brightness) begin
      $display("%0t brightness: expected %0d actual %0d", $realtime, exp_r.brightness,
               got.brightness);
      n_err++;
    end
    if (exp_r.drive_write !== got.drive_write) begin
      $display("%0t drive_write: expected %0d actual %0d", $realtime, exp_r.drive_write,
               got.drive_write);
      n_err++;
    end
    if (exp_r.dim_phase !== got.dim_phase) begin
      $display("%0t dim_phase: expected %0d actual %0d", $realtime, exp_r.dim_phase,
               got.dim_phase);
      n_err++;
    end
    if (exp_r.ignore_touch !== got.ignore_touch) begin
      $display("%0t ignore_touch: expected %0d actual %0d", $realtime, exp_r.ignore_touch,
               got.ignore_touch);
      n_err++;
    end
    if (exp_r.lux_smoothed !== got.lux_smoothed) begin
      $display("%0t lux_smoothed: expected %0d actual %0d", $realtime, exp_r.lux_smoothed,
               got.lux_smoothed);
      n_err++;
    end
    if (exp_r.ambient_target !== got.ambient_target) begin
      $display("%0t ambient_target: expected %0d actual %0d", $realtime,
               exp_r.ambient_target, got.ambient_target);
      n_err++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t        got;
    bld_pkg::item_t it;
    if (!rst_ni) begin
      r_enable    = bld_pkg::RST_DIM_ENABLE;
      r_dim_level = bld_pkg::RST_DIM_LEVEL;
      r_interval  = bld_pkg::RST_DIM_INTERVAL;
      r_start     = bld_pkg::RST_START_BRIGHT;
      r_lux_min   = bld_pkg::RST_LUX_MIN;
      r_lux_max   = bld_pkg::RST_LUX_MAX;
      r_amb_min   = bld_pkg::RST_AMBIENT_MIN;
      r_alpha     = bld_pkg::RST_SMOOTH_ALPHA;
      ph          = bld_pkg::PH_WAIT;
      captured    = 1'b0;
      baseline    = 0;
      lamp        = 0;
      goal        = 0;
      saved       = pct_clip(r_start);
      idle_ms     = 0;
      fade_ms     = 0;
      wake_ms     = 0;
      lux_avg     = 0;
      amb_goal    = 0;
      expected_q.delete();
      n_err       = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.brightness     = out_mon.brightness;
        got.drive_write    = out_mon.drive_write;
        got.dim_phase      = bld_pkg::phase_e'(out_mon.dim_phase);
        got.ignore_touch   = out_mon.ignore_touch;
        got.lux_smoothed   = out_mon.lux_smoothed;
        got.ambient_target = out_mon.ambient_target;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $realtime, got);
          n_err++;
        end else begin
          check_result(expected_q.pop_front(), got);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (bld_pkg::reg_e'(cfg_mon.index))
          bld_pkg::REG_DIM_ENABLE:   r_enable    = cfg_mon.data[0];
          bld_pkg::REG_DIM_LEVEL:    r_dim_level = cfg_mon.data[6:0];
          bld_pkg::REG_DIM_INTERVAL: r_interval  = cfg_mon.data[11:0];
          bld_pkg::REG_START_BRIGHT: begin
            r_start = cfg_mon.data[6:0];
            saved   = pct_clip(r_start);
          end
          bld_pkg::REG_LUX_MIN:      r_lux_min   = cfg_mon.data;
          bld_pkg::REG_LUX_MAX:      r_lux_max   = cfg_mon.data;
          bld_pkg::REG_AMBIENT_MIN:  r_amb_min   = cfg_mon.data[6:0];
          bld_pkg::REG_SMOOTH_ALPHA: r_alpha     = cfg_mon.data[6:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it.action    = bld_pkg::action_e'(in_mon.action);
        it.value     = in_mon.value;
        it.suspended = in_mon.suspended;
        expected_q.push_back(dimmer_step(it));
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the backlight auto dimmer: directed events at
// reset defaults, then random event mixes under several register settings,
// one long tick run through the fading phase, bursty input traffic and a
// stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 120;
  localparam int N_SETTINGS  = 6;
  localparam int FADE_TICKS  = 1050;

  logic clk_i;
  logic rst_ni;
  int   errors, pending;
  int   n_items, n_results, n_writes, stall_cnt, burst_left;

  bld_in_if  in_bus ();
  bld_cfg_if cfg_bus ();
  bld_out_if out_bus ();

  backlight_auto_dimmer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  bld_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .cfg_mon   (cfg_bus),
    .out_mon   (out_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // result receiver stall pattern
  int rx_mode, rx_left, rx_cyc;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 3) != 0);
      2: out_bus.ready <= ($urandom_range(0, 3) == 0);
      default: out_bus.ready <= (rx_cyc % 16 > 11);
    endcase
  end

  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) n_results++;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cnt);
        $display("backlight_auto_dimmer: mismatch");
        $finish;
      end
    end
  end

  task automatic send(bld_pkg::action_e act, logic [15:0] val, logic susp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.value     <= val;
    in_bus.suspended <= susp;
    @(negedge clk_i);
    while (!in_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    burst_left--;
    n_items++;
  endtask

  task automatic write_reg(bld_pkg::reg_e idx, logic [15:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(negedge clk_i);
    while (!cfg_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    n_writes++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (n_results != n_items) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [15:0] user_pct();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 100));
      1: return 16'($urandom_range(0, 8));
      2: return 16'($urandom_range(101, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] raw_lux();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 2000));
      2: return 16'($urandom_range(7800, 65535));
      3: return 16'($urandom_range(0, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  // tick_heavy: mostly millisecond ticks with rare events
  task automatic random_item(bit tick_heavy);
    int      r;
    bld_pkg::action_e act;
    logic [15:0] val;
    r   = $urandom_range(0, 99);
    val = 16'($urandom);
    if (tick_heavy) begin
      if (r < 95) act = bld_pkg::ACT_TICK;
      else if (r < 96) act = bld_pkg::ACT_ACTIVITY;
      else if (r < 97) act = bld_pkg::ACT_MODE;
      else if (r < 98) act = bld_pkg::ACT_WAKE;
      else if (r < 99) act = bld_pkg::ACT_LUX;
      else act = bld_pkg::ACT_RESTORE;
    end else begin
      if (r < 40) act = bld_pkg::ACT_TICK;
      else if (r < 50) act = bld_pkg::ACT_ACTIVITY;
      else if (r < 56) act = bld_pkg::ACT_WAKE;
      else if (r < 61) act = bld_pkg::ACT_RESTORE;
      else if (r < 67) act = bld_pkg::ACT_SET_USER;
      else if (r < 73) act = bld_pkg::ACT_MODE;
      else if (r < 97) act = bld_pkg::ACT_LUX;
      else act = bld_pkg::ACT_NOP;
    end
    if (act == bld_pkg::ACT_SET_USER) val = user_pct();
    if (act == bld_pkg::ACT_LUX) val = raw_lux();
    send(act, val, ($urandom_range(0, 9) == 0));
  endtask

  task automatic load_setting(int s);
    case (s)
      1: begin
        write_reg(bld_pkg::REG_DIM_ENABLE, 16'd1);
        write_reg(bld_pkg::REG_DIM_LEVEL, 16'd0);
        write_reg(bld_pkg::REG_DIM_INTERVAL, 16'd0);
        write_reg(bld_pkg::REG_START_BRIGHT, 16'd0);
        write_reg(bld_pkg::REG_LUX_MIN, 16'd0);
        write_reg(bld_pkg::REG_LUX_MAX, 16'd65535);
        write_reg(bld_pkg::REG_AMBIENT_MIN, 16'd0);
        write_reg(bld_pkg::REG_SMOOTH_ALPHA, 16'd100);
      end
      2: begin
        write_reg(bld_pkg::REG_DIM_ENABLE, 16'd0);
        write_reg(bld_pkg::REG_DIM_LEVEL, 16'd100);
        write_reg(bld_pkg::REG_DIM_INTERVAL, 16'd4095);
        write_reg(bld_pkg::REG_START_BRIGHT, 16'd127);
        write_reg(bld_pkg::REG_LUX_MIN, 16'd65535);
        write_reg(bld_pkg::REG_LUX_MAX, 16'd0);
        write_reg(bld_pkg::REG_AMBIENT_MIN, 16'd100);
        write_reg(bld_pkg::REG_SMOOTH_ALPHA, 16'd0);
      end
      3: begin
        write_reg(bld_pkg::REG_DIM_ENABLE, 16'd1);
        write_reg(bld_pkg::REG_DIM_LEVEL, 16'd127);
        write_reg(bld_pkg::REG_DIM_INTERVAL, 16'd1);
        write_reg(bld_pkg::REG_START_BRIGHT, 16'd100);
        write_reg(bld_pkg::REG_LUX_MIN, 16'd500);
        write_reg(bld_pkg::REG_LUX_MAX, 16'd500);
        write_reg(bld_pkg::REG_AMBIENT_MIN, 16'd127);
        write_reg(bld_pkg::REG_SMOOTH_ALPHA, 16'd127);
      end
      4: begin
        write_reg(bld_pkg::REG_DIM_LEVEL, 16'($urandom_range(0, 4)));
        write_reg(bld_pkg::REG_START_BRIGHT, 16'd50);
        write_reg(bld_pkg::REG_LUX_MIN, 16'd10);
        write_reg(bld_pkg::REG_LUX_MAX, 16'd8000);
        write_reg(bld_pkg::REG_AMBIENT_MIN, 16'd5);
        write_reg(bld_pkg::REG_SMOOTH_ALPHA, 16'd25);
      end
      default: begin
        write_reg(bld_pkg::REG_DIM_ENABLE, 16'($urandom_range(0, 7) != 0));
        write_reg(bld_pkg::REG_DIM_LEVEL, 16'($urandom_range(0, 100)));
        write_reg(bld_pkg::REG_DIM_INTERVAL, 16'($urandom_range(1, 2)));
        write_reg(bld_pkg::REG_START_BRIGHT, 16'($urandom_range(0, 100)));
        write_reg(bld_pkg::REG_LUX_MIN, 16'($urandom_range(0, 3000)));
        write_reg(bld_pkg::REG_LUX_MAX, 16'($urandom_range(0, 65535)));
        write_reg(bld_pkg::REG_AMBIENT_MIN, 16'($urandom_range(0, 100)));
        write_reg(bld_pkg::REG_SMOOTH_ALPHA, 16'($urandom_range(0, 100)));
      end
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.action    <= bld_pkg::ACT_NOP;
    in_bus.value     <= '0;
    in_bus.suspended <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= bld_pkg::REG_DIM_ENABLE;
    cfg_bus.data     <= '0;
    n_items = 0;
    n_results = 0;
    n_writes = 0;
    stall_cnt = 0;
    burst_left = 0;
    rx_left = 0;
    rx_cyc = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(bld_pkg::ACT_NOP, 16'hFFFF, 1'b1);
    send(bld_pkg::ACT_TICK, 16'h0000, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd0, 1'b0);
    send(bld_pkg::ACT_LUX, 16'hFFFF, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd7864, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd7865, 1'b0);
    send(bld_pkg::ACT_SET_USER, 16'd0, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd300, 1'b0);
    send(bld_pkg::ACT_SET_USER, 16'd100, 1'b0);
    send(bld_pkg::ACT_SET_USER, 16'hFFFF, 1'b1);
    send(bld_pkg::ACT_ACTIVITY, 16'hFFFF, 1'b0);
    send(bld_pkg::ACT_WAKE, 16'h5A5A, 1'b0);
    send(bld_pkg::ACT_RESTORE, 16'hA5A5, 1'b1);
    send(bld_pkg::ACT_MODE, 16'h0000, 1'b1);
    send(bld_pkg::ACT_MODE, 16'h0000, 1'b0);
    send(bld_pkg::ACT_TICK, 16'hFFFF, 1'b1);
    send(bld_pkg::ACT_LUX, 16'd1200, 1'b1);
    send(bld_pkg::ACT_SET_USER, 16'd40, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd300, 1'b0);
    send(bld_pkg::ACT_LUX, 16'd300, 1'b0);
    send(bld_pkg::ACT_WAKE, 16'h0000, 1'b1);
    repeat (200) random_item(1'b0);
    drain();

    for (int s = 1; s < N_SETTINGS; s++) begin
      load_setting(s);
      if (s == 1) begin
        // zero idle interval: the first tick starts the fade, one step lands later
        send(bld_pkg::ACT_SET_USER, 16'd1, 1'b0);
        repeat (FADE_TICKS) send(bld_pkg::ACT_TICK, 16'($urandom), 1'b0);
      end
      repeat (100) random_item(1'b0);
      if (s == 3 || s == 5) repeat (50) random_item(1'b1);
      drain();
    end

    $display("%0d input transactions, %0d result transactions, %0d register writes",
             n_items, n_results, n_writes);
    $display("reset defaults and %0d register settings, with a %0d-tick run through a fade step",
             N_SETTINGS - 1, FADE_TICKS);
    if (errors == 0 && pending == 0) begin
      $display("backlight_auto_dimmer: match");
    end else begin
      $display("backlight_auto_dimmer: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bld_pkg.sv
rtl/core/bld_if.sv
rtl/core/bld_front.sv
rtl/core/bld_div.sv
rtl/core/bld_core.sv
rtl/core/backlight_auto_dimmer.sv
tb/bld_checker.sv
tb/testbench.sv
